// File: sv/sld_pkg.sv
// Shared types, constants and the dither table of the scaler with ordered dither.
// Used by every module of the block; depends on nothing else.
package sld_pkg;

    localparam int SRC_WIDTH  = 256;
    localparam int SRC_HEIGHT = 240;

    localparam int ACC_W  = 25;
    localparam int OCOL_W = 9;
    localparam int OROW_W = 8;
    localparam int POS_W  = 8;
    localparam int CFG_W  = 25;
    localparam int IDX_W  = 3;

    localparam logic [POS_W-1:0] SRC_COL_LAST = POS_W'(SRC_WIDTH - 1);
    localparam logic [POS_W-1:0] SRC_ROW_LAST = POS_W'(SRC_HEIGHT - 1);
    localparam logic [ACC_W-1:0] ACC_MAX      = '1;

    typedef enum logic [IDX_W-1:0] {
        CFG_OUTPUT_WIDTH  = 3'd0,
        CFG_OUTPUT_HEIGHT = 3'd1,
        CFG_OFFSET_X      = 3'd2,
        CFG_OFFSET_Y      = 3'd3,
        CFG_STEP_X        = 3'd4,
        CFG_STEP_Y        = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [OCOL_W-1:0] output_width;
        logic [OROW_W-1:0] output_height;
        logic [POS_W-1:0]  offset_x;
        logic [POS_W-1:0]  offset_y;
        logic [24:0]       step_x;
        logic [23:0]       step_y;
    } t_cfg;

    typedef struct packed {
        logic              hit;
        logic [OCOL_W-1:0] out_col;
        logic [OROW_W-1:0] out_row;
        logic [POS_W-1:0]  screen_x;
        logic [POS_W-1:0]  screen_y;
        logic              last;
    } t_pick;

    localparam logic [5:0] BAYER [64] = '{
         6'd0, 6'd32,  6'd8, 6'd40,  6'd2, 6'd34, 6'd10, 6'd42,
        6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
        6'd12, 6'd44,  6'd4, 6'd36, 6'd14, 6'd46,  6'd6, 6'd38,
        6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
         6'd3, 6'd35, 6'd11, 6'd43,  6'd1, 6'd33,  6'd9, 6'd41,
        6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
        6'd15, 6'd47,  6'd7, 6'd39, 6'd13, 6'd45,  6'd5, 6'd37,
        6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
    };

    function automatic logic [ACC_W-1:0] add_sat(input logic [ACC_W-1:0] acc,
                                                 input logic [ACC_W-1:0] step);
        logic [ACC_W:0] sum;
        sum = {1'b0, acc} + {1'b0, step};
        return sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
    endfunction

endpackage

// File: sv/sld_cfg_regs.sv
// Configuration register file with its reset defaults.
// Depends on sld_pkg for the register layout and indexes.
module sld_cfg_regs import sld_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_OUTPUT_WIDTH:  n_cfg.output_width  = i_cfg_data[OCOL_W-1:0];
                CFG_OUTPUT_HEIGHT: n_cfg.output_height = i_cfg_data[OROW_W-1:0];
                CFG_OFFSET_X:      n_cfg.offset_x      = i_cfg_data[POS_W-1:0];
                CFG_OFFSET_Y:      n_cfg.offset_y      = i_cfg_data[POS_W-1:0];
                CFG_STEP_X:        n_cfg.step_x        = i_cfg_data[24:0];
                CFG_STEP_Y:        n_cfg.step_y        = i_cfg_data[23:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_width  <= 9'd117;
            r_cfg.output_height <= 8'd110;
            r_cfg.offset_x      <= 8'd10;
            r_cfg.offset_y      <= 8'd0;
            r_cfg.step_x        <= 25'd143395;
            r_cfg.step_y        <= 24'd142987;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/sld_scan_ctrl.sv
// Source and output position counters with the 9.16 step accumulators.
// Decides which arriving pixels are picked; depends on sld_pkg.
module sld_scan_ctrl import sld_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_accept,
    input  logic  i_frame_start,
    output t_pick o_pick
);

    logic [POS_W-1:0]  r_src_col, n_src_col, c_src_col;
    logic [POS_W-1:0]  r_src_row, n_src_row, c_src_row;
    logic [ACC_W-1:0]  r_col_acc, n_col_acc, c_col_acc;
    logic [ACC_W-1:0]  r_row_acc, n_row_acc, c_row_acc;
    logic [OCOL_W-1:0] r_out_col, n_out_col, c_out_col;
    logic [OROW_W-1:0] r_out_row, n_out_row, c_out_row;
    logic              row_hit;
    logic              hit;

    always_comb begin
        c_src_col = i_frame_start ? '0 : r_src_col;
        c_src_row = i_frame_start ? '0 : r_src_row;
        c_col_acc = i_frame_start ? '0 : r_col_acc;
        c_row_acc = i_frame_start ? '0 : r_row_acc;
        c_out_col = i_frame_start ? '0 : r_out_col;
        c_out_row = i_frame_start ? '0 : r_out_row;

        row_hit = (c_out_row < i_cfg.output_height) &&
                  ({1'b0, c_src_row} == c_row_acc[ACC_W-1:16]);
        hit     = row_hit && (c_out_col < i_cfg.output_width) &&
                  ({1'b0, c_src_col} == c_col_acc[ACC_W-1:16]);

        n_src_col = c_src_col;
        n_src_row = c_src_row;
        n_col_acc = c_col_acc;
        n_row_acc = c_row_acc;
        n_out_col = c_out_col;
        n_out_row = c_out_row;

        if (hit) begin
            n_out_col = c_out_col + 1'b1;
            n_col_acc = add_sat(c_col_acc, i_cfg.step_x);
        end

        if (c_src_col >= SRC_COL_LAST) begin
            n_src_col = '0;
            n_col_acc = '0;
            n_out_col = '0;
            if (c_src_row >= SRC_ROW_LAST) begin
                n_src_row = '0;
                n_row_acc = '0;
                n_out_row = '0;
            end else begin
                if (row_hit) begin
                    n_out_row = c_out_row + 1'b1;
                    n_row_acc = add_sat(c_row_acc, {1'b0, i_cfg.step_y});
                end
                n_src_row = c_src_row + 1'b1;
            end
        end else begin
            n_src_col = c_src_col + 1'b1;
        end

        o_pick.hit      = hit;
        o_pick.out_col  = c_out_col;
        o_pick.out_row  = c_out_row;
        o_pick.screen_x = i_cfg.offset_x + c_out_col[POS_W-1:0];
        o_pick.screen_y = i_cfg.offset_y + c_out_row;
        o_pick.last     = ({1'b0, c_out_col} + 1'b1 == {1'b0, i_cfg.output_width}) &&
                          ({1'b0, c_out_row} + 1'b1 == {1'b0, i_cfg.output_height});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_col_acc <= '0;
            r_row_acc <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_accept) begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_col_acc <= n_col_acc;
            r_row_acc <= n_row_acc;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

// File: sv/sld_grey.sv
// Integer luma and 8x8 ordered dither down to four grey levels.
// Purely combinational; depends on sld_pkg for the dither table.
module sld_grey import sld_pkg::*; (
    input  logic [31:0]       i_pixel_argb,
    input  logic [OCOL_W-1:0] i_out_col,
    input  logic [OROW_W-1:0] i_out_row,
    output logic [1:0]        o_grey_level
);

    logic [7:0]  red, green, blue;
    logic [15:0] luma_sum;
    logic [5:0]  bayer;
    logic [10:0] dithered;
    logic [10:0] biased;

    always_comb begin
        red      = i_pixel_argb[23:16];
        green    = i_pixel_argb[15:8];
        blue     = i_pixel_argb[7:0];
        luma_sum = 16'(16'd77 * red) + 16'(16'd150 * green) + 16'(16'd29 * blue);
        bayer    = BAYER[{i_out_row[2:0], i_out_col[2:0]}];
        dithered = {1'b0, luma_sum[15:8], 2'b00} + {5'd0, bayer};
        biased   = dithered - 11'd32;
        if (dithered < 11'd32) begin
            o_grey_level = 2'd0;
        end else if (biased[10:8] > 3'd3) begin
            o_grey_level = 2'd3;
        end else begin
            o_grey_level = biased[9:8];
        end
    end

endmodule

// File: sv/scale_luma_bayer_dither_top.sv
// A result is registered in the output register and appears in the cycle after its pixel is accepted.
// Throughput: one pixel per cycle; the output register takes a new result in the cycle
// in which its current one is taken, so the input stalls only while that register is
// full and not taken.
// Reset (synchronous, active low) restores the register defaults, clears all
// position counters and accumulators, and empties the output register.
module scale_luma_bayer_dither_top import sld_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // pixel_argb[31:0]
    input  logic [31:0]      s_axis_tdata,
    // frame_start[0]
    input  logic             s_axis_tuser,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // grey_level[1:0], screen_x[9:2], screen_y[17:10], zero fill[23:18]
    output logic [23:0]      m_axis_tdata,
    // frame_done
    output logic             m_axis_tlast
);

    t_cfg       cfg;
    t_pick      pick;
    logic [1:0] grey_level;
    logic       in_accept;

    logic        r_valid, n_valid;
    logic [23:0] r_data;
    logic        r_last;

    sld_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    sld_scan_ctrl u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_accept      (in_accept),
        .i_frame_start (s_axis_tuser),
        .o_pick        (pick)
    );

    sld_grey u_grey (
        .i_pixel_argb (s_axis_tdata),
        .i_out_col    (pick.out_col),
        .i_out_row    (pick.out_row),
        .o_grey_level (grey_level)
    );

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_valid = r_valid && !m_axis_tready;
        if (in_accept) begin
            n_valid = pick.hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && pick.hit) begin
            r_data <= {6'd0, pick.screen_y, pick.screen_x, grey_level};
            r_last <= pick.last;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = r_data;
    assign m_axis_tlast  = r_last;

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output register");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid straight after reset");

    a_hit_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && pick.hit) |=> m_axis_tvalid)
        else $error("picked item produced no result");

    a_miss_gives_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !pick.hit) |=> !m_axis_tvalid)
        else $error("result shown for an item that was not picked");

endmodule

// File: sim/sld_checker.sv
// Checker for the downscaler with ordered dither: it mirrors the registers and position
// counters, predicts every grey pixel from the accepted source pixels and compares results.
// Depends on sld_pkg for the register index type and the port widths.
`timescale 1ns / 1ps
module sld_checker import sld_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_pix_valid,
    input  logic             i_pix_ready,
    // pixel_argb[31:0]
    input  logic [31:0]      i_pix_data,
    // frame_start[0]
    input  logic             i_pix_start,
    input  logic             i_grey_valid,
    input  logic             i_grey_ready,
    // grey_level[1:0], screen_x[9:2], screen_y[17:10], zero fill[23:18]
    input  logic [23:0]      i_grey_data,
    input  logic             i_grey_last,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [1:0] level;
        logic [7:0] screen_x;
        logic [7:0] screen_y;
        logic       frame_done;
    } t_grey_pixel;

    localparam logic [5:0] DITHER_8X8 [64] = '{
         6'd0, 6'd32,  6'd8, 6'd40,  6'd2, 6'd34, 6'd10, 6'd42,
        6'd48, 6'd16, 6'd56, 6'd24, 6'd50, 6'd18, 6'd58, 6'd26,
        6'd12, 6'd44,  6'd4, 6'd36, 6'd14, 6'd46,  6'd6, 6'd38,
        6'd60, 6'd28, 6'd52, 6'd20, 6'd62, 6'd30, 6'd54, 6'd22,
         6'd3, 6'd35, 6'd11, 6'd43,  6'd1, 6'd33,  6'd9, 6'd41,
        6'd51, 6'd19, 6'd59, 6'd27, 6'd49, 6'd17, 6'd57, 6'd25,
        6'd15, 6'd47,  6'd7, 6'd39, 6'd13, 6'd45,  6'd5, 6'd37,
        6'd63, 6'd31, 6'd55, 6'd23, 6'd61, 6'd29, 6'd53, 6'd21
    };

    t_cfg        regs;
    logic [7:0]  src_col;
    logic [7:0]  src_row;
    logic [24:0] col_acc;
    logic [24:0] row_acc;
    logic [8:0]  out_col;
    logic [7:0]  out_row;
    t_grey_pixel expected_pixels [$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [24:0] advance_pick(input logic [24:0] acc, input logic [24:0] step);
        logic [25:0] total;
        total = 26'(acc) + 26'(step);
        return (total > 26'h1FFFFFF) ? 25'h1FFFFFF : total[24:0];
    endfunction

    function automatic logic [1:0] dithered_grey(input logic [31:0] px, input logic [5:0] thr);
        int unsigned luma;
        int unsigned biased;
        luma = (77 * int'(px[23:16]) + 150 * int'(px[15:8]) + 29 * int'(px[7:0])) >> 8;
        biased = luma * 4 + int'(thr);
        if (biased < 32) begin
            return 2'd0;
        end
        biased = (biased - 32) >> 8;
        return (biased > 3) ? 2'd3 : 2'(biased);
    endfunction

    task automatic clear_position();
        src_col = '0;
        src_row = '0;
        col_acc = '0;
        row_acc = '0;
        out_col = '0;
        out_row = '0;
    endtask

    task automatic flag_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // Follows one accepted source pixel and queues the grey pixel it produces, if any.
    task automatic take_source_pixel(input logic [31:0] px, input logic start);
        logic        row_hit;
        t_grey_pixel gp;
        if (start) begin
            clear_position();
        end
        row_hit = (out_row < regs.output_height) && ({1'b0, src_row} == row_acc[24:16]);
        if (row_hit && out_col < regs.output_width && {1'b0, src_col} == col_acc[24:16]) begin
            gp.level      = dithered_grey(px, DITHER_8X8[{out_row[2:0], out_col[2:0]}]);
            gp.screen_x   = regs.offset_x + out_col[7:0];
            gp.screen_y   = regs.offset_y + out_row;
            gp.frame_done = (10'(out_col) + 10'd1 == 10'(regs.output_width))
                            && (9'(out_row) + 9'd1 == 9'(regs.output_height));
            expected_pixels.push_back(gp);
            out_col = out_col + 9'd1;
            col_acc = advance_pick(col_acc, regs.step_x);
        end
        if (src_col == 8'd255) begin
            src_col = '0;
            col_acc = '0;
            out_col = '0;
            if (src_row >= 8'(SRC_HEIGHT - 1)) begin
                clear_position();
            end else begin
                if (row_hit) begin
                    out_row = out_row + 8'd1;
                    row_acc = advance_pick(row_acc, 25'(regs.step_y));
                end
                src_row = src_row + 8'd1;
            end
        end else begin
            src_col = src_col + 8'd1;
        end
    endtask

    always @(posedge i_clk) begin
        t_grey_pixel gp;
        if (!i_rst_n) begin
            regs.output_width  = 9'd117;
            regs.output_height = 8'd110;
            regs.offset_x      = 8'd10;
            regs.offset_y      = 8'd0;
            regs.step_x        = 25'd143395;
            regs.step_y        = 24'd142987;
            clear_position();
            expected_pixels.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_OUTPUT_WIDTH:  regs.output_width  = i_cfg_data[8:0];
                    CFG_OUTPUT_HEIGHT: regs.output_height = i_cfg_data[7:0];
                    CFG_OFFSET_X:      regs.offset_x      = i_cfg_data[7:0];
                    CFG_OFFSET_Y:      regs.offset_y      = i_cfg_data[7:0];
                    CFG_STEP_X:        regs.step_x        = i_cfg_data[24:0];
                    CFG_STEP_Y:        regs.step_y        = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            if (i_grey_valid && i_grey_ready) begin
                if (expected_pixels.size() == 0) begin
                    flag_mismatch("unexpected grey pixel", 0, i_grey_data);
                end else begin
                    gp = expected_pixels.pop_front();
                    if (i_grey_data[1:0] !== gp.level)
                        flag_mismatch("grey_level", gp.level, i_grey_data[1:0]);
                    if (i_grey_data[9:2] !== gp.screen_x)
                        flag_mismatch("screen_x", gp.screen_x, i_grey_data[9:2]);
                    if (i_grey_data[17:10] !== gp.screen_y)
                        flag_mismatch("screen_y", gp.screen_y, i_grey_data[17:10]);
                    if (i_grey_last !== gp.frame_done)
                        flag_mismatch("frame_done", gp.frame_done, i_grey_last);
                end
            end
            if (i_pix_valid && i_pix_ready) begin
                take_source_pixel(i_pix_data, i_pix_start);
            end
        end
        o_pending = expected_pixels.size();
    end

endmodule

// File: sim/tb_top.sv
// Testbench top for scale_luma_bayer_dither_top: drives reset, register writes and source
// pixels with random idling, and gives the verdict. Depends on sld_pkg and sld_checker.
`timescale 1ns / 1ps
module tb_top;
    import sld_pkg::*;

    localparam int RANDOM_ITEMS = 1870;
    localparam int CALM_ITEMS   = 300;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [31:0] EDGE_PIXELS [16] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_0000, 32'h0000_FF00,
        32'h0000_00FF, 32'hFF00_0000, 32'h00FF_FFFF, 32'h0001_0101,
        32'h0008_0808, 32'h0020_2020, 32'h0040_4040, 32'h0080_8080,
        32'h00FF_FFFF, 32'h00C0_C0C0, 32'h1234_5678, 32'h8765_4321
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic             pix_valid;
    logic             pix_ready;
    logic [31:0]      pix_data;
    logic             pix_start;
    logic             grey_valid;
    logic             grey_ready;
    logic [23:0]      grey_data;
    logic             grey_last;
    int               fail_count;
    int               pending;
    int               gap_odds;
    int               hold_reqs;
    logic             calm;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    scale_luma_bayer_dither_top dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .s_axis_tvalid(pix_valid),
        .s_axis_tready(pix_ready),
        .s_axis_tdata (pix_data),
        .s_axis_tuser (pix_start),
        .m_axis_tvalid(grey_valid),
        .m_axis_tready(grey_ready),
        .m_axis_tdata (grey_data),
        .m_axis_tlast (grey_last)
    );

    sld_checker grey_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_pix_valid (pix_valid),
        .i_pix_ready (pix_ready),
        .i_pix_data  (pix_data),
        .i_pix_start (pix_start),
        .i_grey_valid(grey_valid),
        .i_grey_ready(grey_ready),
        .i_grey_data (grey_data),
        .i_grey_last (grey_last),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    task automatic send_pixel(input logic [31:0] px, input logic start);
        if (!calm && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        pix_start <= start;
        do @(posedge clk); while (!pix_ready);
        @(negedge clk);
    endtask

    // The block may still be working on an item that gives no result, so the bench
    // waits after the last grey pixel before the registers are touched.
    task automatic drain();
        pix_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    function automatic logic [31:0] random_pixel();
        logic [7:0] v;
        v = 8'($urandom);
        return ($urandom_range(0, 3) == 0) ? {8'($urandom), v, v, v} : $urandom;
    endfunction

    function automatic logic [CFG_W-1:0] pick_reg_value(input t_cfg_idx idx);
        logic [CFG_W-1:0] v;
        v = '0;
        case (idx)
            CFG_OUTPUT_WIDTH: begin
                case ($urandom_range(0, 7))
                    0: v = 25'd0;
                    1: v = 25'd1;
                    2: v = 25'd256;
                    3: v = 25'd511;
                    default: v = CFG_W'($urandom_range(8, 256));
                endcase
            end
            CFG_OUTPUT_HEIGHT: begin
                case ($urandom_range(0, 7))
                    0: v = 25'd0;
                    1: v = 25'd1;
                    2: v = 25'd2;
                    3: v = 25'd255;
                    4: v = 25'd240;
                    default: v = CFG_W'($urandom_range(1, 240));
                endcase
            end
            CFG_OFFSET_X, CFG_OFFSET_Y: begin
                v = CFG_W'($urandom_range(0, 255));
                if ($urandom_range(0, 5) == 0) begin
                    v[24:8] = 17'($urandom);
                end
            end
            CFG_STEP_X: begin
                case ($urandom_range(0, 7))
                    0: v = 25'h001_0000;
                    1: v = 25'h1FF_FFFF;
                    2: v = CFG_W'($urandom_range(0, 65535));
                    3: v = CFG_W'($urandom_range(1 << 16, 1 << 24));
                    default: v = CFG_W'($urandom_range(65536, 12 * 65536));
                endcase
            end
            CFG_STEP_Y: begin
                case ($urandom_range(0, 7))
                    0: v = 25'h001_0000;
                    1: v = {1'($urandom), 24'hFF_FFFF};
                    2: v = CFG_W'($urandom_range(0, 65535));
                    3: v = CFG_W'($urandom_range(1 << 16, 15 << 20));
                    default: v = CFG_W'($urandom_range(65536, 4 * 65536));
                endcase
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    // Output side: random short stalls, long stretches of readiness, and one long
    // hold-off whenever the stimulus asks for it.
    initial begin
        int seen;
        int span;
        logic lvl;
        seen = 0;
        grey_ready = 1'b0;
        @(negedge clk);
        forever begin
            if (hold_reqs != seen) begin
                seen = hold_reqs;
                lvl  = 1'b0;
                span = HOLD_CYCLES;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                lvl  = 1'b0;
                span = $urandom_range(1, 5);
            end else begin
                lvl  = 1'b1;
                span = $urandom_range(1, 12);
            end
            grey_ready <= lvl;
            repeat (span) @(negedge clk);
        end
    end

    initial begin
        #100_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int k;
        int r;
        int seg_len;
        int random_items;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        pix_valid = 1'b0;
        pix_data  = '0;
        pix_start = 1'b0;
        gap_odds  = 4;
        hold_reqs = 0;
        calm      = 1'b0;
        random_items = 0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Every source pixel picked, screen x wrapping past its right edge.
        set_reg(CFG_OUTPUT_WIDTH, 25'd256);
        set_reg(CFG_OUTPUT_HEIGHT, 25'd240);
        set_reg(CFG_OFFSET_X, 25'd250);
        set_reg(CFG_OFFSET_Y, 25'd255);
        set_reg(CFG_STEP_X, 25'h001_0000);
        set_reg(CFG_STEP_Y, 25'h001_0000);
        cfg_we <= 1'b0;
        for (k = 0; k < 16; k++) begin
            send_pixel(EDGE_PIXELS[k], k == 0 || k == 12);
        end
        drain();

        // A zero width, then a zero height, emit nothing.
        set_reg(CFG_OUTPUT_WIDTH, 25'd0);
        cfg_we <= 1'b0;
        for (k = 0; k < 3; k++) begin
            send_pixel(random_pixel(), k == 0);
        end
        drain();
        set_reg(CFG_OUTPUT_WIDTH, 25'd256);
        set_reg(CFG_OUTPUT_HEIGHT, 25'd0);
        cfg_we <= 1'b0;
        for (k = 0; k < 2; k++) begin
            send_pixel(random_pixel(), k == 0);
        end
        drain();

        // The output side holds off while pixels keep coming, so the block backs up.
        set_reg(CFG_OUTPUT_HEIGHT, 25'd240);
        cfg_we <= 1'b0;
        hold_reqs++;
        for (k = 0; k < 60; k++) begin
            send_pixel(random_pixel(), k == 0);
        end
        drain();

        while (random_items < RANDOM_ITEMS) begin
            for (r = 0; r < 6; r++) begin
                if ($urandom_range(0, 2) == 0) begin
                    set_reg(t_cfg_idx'(r), pick_reg_value(t_cfg_idx'(r)));
                end
            end
            cfg_we <= 1'b0;
            seg_len = ($urandom_range(0, 4) == 0) ? $urandom_range(256, 700)
                                                  : $urandom_range(10, 120);
            if (seg_len > RANDOM_ITEMS - random_items) begin
                seg_len = RANDOM_ITEMS - random_items;
            end
            case ($urandom_range(0, 2))
                0: gap_odds = 0;
                1: gap_odds = 8;
                default: gap_odds = 3;
            endcase
            for (k = 0; k < seg_len; k++) begin
                if (random_items + k >= RANDOM_ITEMS - CALM_ITEMS) begin
                    calm = 1'b1;
                end
                send_pixel(random_pixel(), (k == 0 && $urandom_range(0, 5) != 0)
                                           || $urandom_range(0, 127) == 0);
            end
            random_items += seg_len;
            drain();
        end

        repeat (10) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
